@@ sv/sqvg_pkg.sv @@
// ----------------------------------------------------------------------------
// sqvg_pkg: shared types and constants of the sprite quad vertex generator
// Request codes, angle constants, arctangent table and the job record that
// travels from the front part to the back part.
// ----------------------------------------------------------------------------
package sqvg_pkg;

	// Request kinds carried in s_tuser.
	localparam logic [1:0] REQ_BEGIN = 2'd0;
	localparam logic [1:0] REQ_ADD   = 2'd1;
	localparam logic [1:0] REQ_END   = 2'd2;

	// Batch capacity, bounded by the 10-bit slot field.
	localparam int unsigned BATCH_SLOTS = 1024;
	localparam int unsigned SLOT_LIMIT  = (BATCH_SLOTS < 1024) ? BATCH_SLOTS : 1024;

	// Angles in units of 2^-16 degree.
	localparam logic [32:0] DEG360 = 33'd23592960;
	localparam logic [32:0] DEG180 = 33'd11796480;
	localparam logic [32:0] DEG90  = 33'd5898240;

	// CORDIC start value (gain compensation), Q2.30.
	localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
	localparam int unsigned CORDIC_STEPS = 16;

	// Texture coordinate ceiling, 1.0 in Q1.15.
	localparam logic [15:0] UV_ONE = 16'd32768;

	// Arctangent of 2^-i in 2^-16 degree units.
	function automatic logic signed [25:0] atan_lut(input logic [3:0] i);
		logic signed [25:0] r;
		begin
			unique case (i)
				4'd0:    r = 26'sd2949120;
				4'd1:    r = 26'sd1740967;
				4'd2:    r = 26'sd919879;
				4'd3:    r = 26'sd466945;
				4'd4:    r = 26'sd234379;
				4'd5:    r = 26'sd117304;
				4'd6:    r = 26'sd58666;
				4'd7:    r = 26'sd29335;
				4'd8:    r = 26'sd14668;
				4'd9:    r = 26'sd7334;
				4'd10:   r = 26'sd3667;
				4'd11:   r = 26'sd1833;
				4'd12:   r = 26'sd917;
				4'd13:   r = 26'sd458;
				4'd14:   r = 26'sd229;
				default: r = 26'sd115;
			endcase
			return r;
		end
	endfunction

	// One expanded sprite, or a reject marker.
	typedef struct packed {
		logic               reject;
		logic [9:0]         slot;
		logic signed [33:0] wp2;   // width - 2*pivot_x
		logic signed [33:0] wn2;   // -width - 2*pivot_x
		logic signed [33:0] hp2;   // height - 2*pivot_y
		logic signed [33:0] hn2;   // -height - 2*pivot_y
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [16:0] cos_v;
		logic signed [16:0] sin_v;
		logic [31:0]        color;
		logic [15:0]        umin;
		logic [15:0]        umax;
		logic [15:0]        vmin;
		logic [15:0]        vmax;
	} job_t;

endpackage

@@ sv/sqvg_queue.sv @@
// ----------------------------------------------------------------------------
// sqvg_queue: two-entry job queue
// Decouples the front part from the back part so that each can stall alone.
// ----------------------------------------------------------------------------
module sqvg_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  sqvg_pkg::job_t  push_data,
	output logic            full,
	input  logic            pop,
	output logic            avail,
	output sqvg_pkg::job_t  head
);

	sqvg_pkg::job_t mem_q [2];
	logic           wr_q;
	logic           rd_q;
	logic [1:0]     cnt_q;

	assign full  = (cnt_q == 2'd2);
	assign avail = (cnt_q != 2'd0);
	assign head  = mem_q[rd_q];

	// Storage writes.
	always_ff @(posedge clk) begin
		if (push && !full) begin
			mem_q[wr_q] <= push_data;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push && !full) begin
				wr_q <= ~wr_q;
			end
			if (pop && avail) begin
				rd_q <= ~rd_q;
			end
			cnt_q <= cnt_q + {1'b0, (push && !full)} - {1'b0, (pop && avail)};
		end
	end

endmodule

@@ sv/sqvg_front.sv @@
// ----------------------------------------------------------------------------
// sqvg_front: request intake and sprite preparation
// Keeps the batch state, reduces the angle modulo 360 degrees, runs an
// iterative CORDIC for sin and cos, and hands one job per sprite onward.
// ----------------------------------------------------------------------------
module sqvg_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  logic [1:0]      req_type,
	input  logic [319:0]    in_data,
	output logic            job_valid,
	output sqvg_pkg::job_t  job,
	input  logic            job_full
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_MOD  = 3'd1;
	localparam logic [2:0] ST_FOLD = 3'd2;
	localparam logic [2:0] ST_CORD = 3'd3;
	localparam logic [2:0] ST_FIN  = 3'd4;
	localparam logic [2:0] ST_PUSH = 3'd5;

	logic [2:0]         state_q;
	logic [3:0]         step_q;
	logic [10:0]        slot_count_q;
	logic               batch_open_q;
	logic               ang_neg_q;
	logic [32:0]        rem_q;
	logic signed [25:0] z_q;
	logic signed [33:0] x_q;
	logic signed [33:0] y_q;
	logic               flip_q;
	logic signed [16:0] cos_q;
	logic signed [16:0] sin_q;
	sqvg_pkg::job_t     job_q;
	sqvg_pkg::job_t     job_new;
	logic               add_reject;

	// Input field views.
	logic signed [31:0] f_pos_x, f_pos_y, f_width, f_height;
	logic signed [31:0] f_piv_x, f_piv_y, f_angle;
	logic [31:0]        f_color, f_uvmin, f_uvmax;

	assign f_pos_x  = in_data[31:0];
	assign f_pos_y  = in_data[63:32];
	assign f_width  = in_data[95:64];
	assign f_height = in_data[127:96];
	assign f_piv_x  = in_data[159:128];
	assign f_piv_y  = in_data[191:160];
	assign f_angle  = in_data[223:192];
	assign f_color  = in_data[255:224];
	assign f_uvmin  = in_data[287:256];
	assign f_uvmax  = in_data[319:288];

	assign in_ready  = (state_q == ST_IDLE);
	assign job_valid = (state_q == ST_PUSH);

	// The outgoing job carries the finished sin and cos.
	always_comb begin
		job       = job_q;
		job.cos_v = cos_q;
		job.sin_v = sin_q;
	end

	function automatic logic [15:0] uv_clamp(input logic [15:0] v);
		begin
			return (v > sqvg_pkg::UV_ONE) ? sqvg_pkg::UV_ONE : v;
		end
	endfunction

	// An add is turned away when the batch is closed or full.
	assign add_reject = !batch_open_q || (slot_count_q >= 11'(sqvg_pkg::SLOT_LIMIT));

	// Job fields taken from an accepted add.
	always_comb begin
		job_new = '0;
		if (add_reject) begin
			job_new.reject = 1'b1;
		end else begin
			job_new.reject = 1'b0;
			job_new.slot   = slot_count_q[9:0];
			job_new.wp2    = 34'(f_width) - (34'(f_piv_x) <<< 1);
			job_new.wn2    = -34'(f_width) - (34'(f_piv_x) <<< 1);
			job_new.hp2    = 34'(f_height) - (34'(f_piv_y) <<< 1);
			job_new.hn2    = -34'(f_height) - (34'(f_piv_y) <<< 1);
			job_new.pos_x  = f_pos_x;
			job_new.pos_y  = f_pos_y;
			job_new.color  = f_color;
			job_new.umin   = uv_clamp(f_uvmin[15:0]);
			job_new.vmin   = uv_clamp(f_uvmin[31:16]);
			job_new.umax   = uv_clamp(f_uvmax[15:0]);
			job_new.vmax   = uv_clamp(f_uvmax[31:16]);
		end
	end

	// Restoring modulo step: one power-of-two multiple of 360 degrees (128 down to 1) tried per cycle.
	logic [32:0] mod_sub;
	assign mod_sub = sqvg_pkg::DEG360 << (3'd7 - step_q[2:0]);

	// Angle into (-180,180] and then folded into [-90,90].
	logic signed [33:0] z_wrap, z_half;
	logic [32:0]        z_pos;
	always_comb begin
		z_pos = (ang_neg_q && rem_q != 33'd0) ? (sqvg_pkg::DEG360 - rem_q) : rem_q;
		z_wrap = (z_pos > sqvg_pkg::DEG180)
		       ? $signed({1'b0, z_pos}) - $signed({1'b0, sqvg_pkg::DEG360})
		       : $signed({1'b0, z_pos});
		z_half = z_wrap;
		if (z_wrap > $signed({1'b0, sqvg_pkg::DEG90})) begin
			z_half = z_wrap - $signed({1'b0, sqvg_pkg::DEG180});
		end else if (z_wrap < -$signed({1'b0, sqvg_pkg::DEG90})) begin
			z_half = z_wrap + $signed({1'b0, sqvg_pkg::DEG180});
		end
	end
	logic fold_flip;
	assign fold_flip = (z_wrap > $signed({1'b0, sqvg_pkg::DEG90}))
	                || (z_wrap < -$signed({1'b0, sqvg_pkg::DEG90}));

	// Rounding of the CORDIC outputs to Q1.15 with clamping and the fold sign.
	logic signed [18:0] xr, yr;
	logic signed [16:0] xc, yc;
	always_comb begin
		xr = 19'((x_q + 34'sd16384) >>> 15);
		yr = 19'((y_q + 34'sd16384) >>> 15);
		xc = (xr > 19'sd32768) ? 17'sd32768 : ((xr < -19'sd32768) ? -17'sd32768 : 17'(xr));
		yc = (yr > 19'sd32768) ? 17'sd32768 : ((yr < -19'sd32768) ? -17'sd32768 : 17'(yr));
	end

	// Request sequencing.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			step_q       <= 4'd0;
			slot_count_q <= 11'd0;
			batch_open_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						unique case (req_type)
							sqvg_pkg::REQ_BEGIN: begin
								batch_open_q <= 1'b1;
								slot_count_q <= 11'd0;
							end
							sqvg_pkg::REQ_END: begin
								batch_open_q <= 1'b0;
							end
							sqvg_pkg::REQ_ADD: begin
								if (add_reject) begin
									state_q <= ST_PUSH;
								end else begin
									slot_count_q <= slot_count_q + 11'd1;
									step_q       <= 4'd0;
									state_q      <= ST_MOD;
								end
							end
							default: begin
							end
						endcase
					end
				end
				ST_MOD: begin
					step_q <= step_q + 4'd1;
					if (step_q == 4'd7) begin
						state_q <= ST_FOLD;
					end
				end
				ST_FOLD: begin
					step_q  <= 4'd0;
					state_q <= ST_CORD;
				end
				ST_CORD: begin
					step_q <= step_q + 4'd1;
					if (step_q == 4'(sqvg_pkg::CORDIC_STEPS - 1)) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					state_q <= ST_PUSH;
				end
				ST_PUSH: begin
					if (!job_full) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Datapath registers for the job under preparation.
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid && req_type == sqvg_pkg::REQ_ADD) begin
					job_q     <= job_new;
					cos_q     <= 17'sd0;
					sin_q     <= 17'sd0;
					ang_neg_q <= f_angle[31];
					rem_q     <= f_angle[31] ? (33'd0 - 33'(f_angle)) : 33'(f_angle);
				end
			end
			ST_MOD: begin
				if (rem_q >= mod_sub) begin
					rem_q <= rem_q - mod_sub;
				end
			end
			ST_FOLD: begin
				z_q    <= 26'(z_half);
				flip_q <= fold_flip;
				x_q    <= sqvg_pkg::CORDIC_GAIN;
				y_q    <= 34'sd0;
			end
			ST_CORD: begin
				if (z_q >= 26'sd0) begin
					x_q <= x_q - (y_q >>> step_q);
					y_q <= y_q + (x_q >>> step_q);
					z_q <= z_q - sqvg_pkg::atan_lut(step_q);
				end else begin
					x_q <= x_q + (y_q >>> step_q);
					y_q <= y_q - (x_q >>> step_q);
					z_q <= z_q + sqvg_pkg::atan_lut(step_q);
				end
			end
			ST_FIN: begin
				cos_q <= flip_q ? -xc : xc;
				sin_q <= flip_q ? -yc : yc;
			end
			default: begin
			end
		endcase
	end

endmodule

@@ sv/sqvg_back.sv @@
// ----------------------------------------------------------------------------
// sqvg_back: corner expansion
// Emits the four corners of a queued sprite (one word for a reject), one per
// cycle while out_ready allows, via multiply, round-and-saturate, output reg.
// ----------------------------------------------------------------------------
module sqvg_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            job_avail,
	input  sqvg_pkg::job_t  job,
	output logic            job_pop,
	output logic            out_valid,
	input  logic            out_ready,
	output logic [143:0]    out_data,
	output logic            out_status,
	output logic            out_last
);

	logic [1:0]         corner_q;
	logic               vld_s1, rej_s1, last_s1;
	logic [9:0]         slot_s1;
	logic [1:0]         corner_s1;
	logic signed [50:0] pxc_s1, pys_s1, pyc_s1, pxs_s1;
	logic signed [31:0] posx_s1, posy_s1;
	logic [31:0]        color_s1;
	logic [15:0]        tu_s1, tv_s1;
	logic               out_valid_q, status_q, last_q;
	logic [143:0]       data_q;

	logic adv2, adv1, take, xpos, ypos, corner_done;
	logic signed [33:0] px2, py2;

	assign adv2        = !out_valid_q || out_ready;
	assign adv1        = !vld_s1 || adv2;
	assign take        = job_avail && adv1;
	assign xpos        = (corner_q == 2'd1) || (corner_q == 2'd2);
	assign ypos        = corner_q[1];
	assign px2         = xpos ? job.wp2 : job.wn2;
	assign py2         = ypos ? job.hp2 : job.hn2;
	assign corner_done = job.reject || (corner_q == 2'd3);
	assign job_pop     = take && corner_done;

	assign out_valid  = out_valid_q;
	assign out_data   = data_q;
	assign out_status = status_q;
	assign out_last   = last_q;

	// Corner sequencing and stage valids.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			corner_q    <= 2'd0;
			vld_s1      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (take) begin
				corner_q <= corner_done ? 2'd0 : corner_q + 2'd1;
			end
			if (adv1) begin
				vld_s1 <= take;
			end
			if (adv2) begin
				out_valid_q <= vld_s1;
			end
		end
	end

	// Multiply stage.
	always_ff @(posedge clk) begin
		if (take) begin
			rej_s1    <= job.reject;
			last_s1   <= corner_done;
			slot_s1   <= job.slot;
			corner_s1 <= corner_q;
			pxc_s1    <= 51'(px2) * 51'(job.cos_v);
			pys_s1    <= 51'(py2) * 51'(job.sin_v);
			pyc_s1    <= 51'(py2) * 51'(job.cos_v);
			pxs_s1    <= 51'(px2) * 51'(job.sin_v);
			posx_s1   <= job.pos_x;
			posy_s1   <= job.pos_y;
			color_s1  <= job.color;
			tu_s1     <= xpos ? job.umax : job.umin;
			tv_s1     <= ypos ? job.vmin : job.vmax;
		end
	end

	// Rounding, position add and saturation.
	logic signed [51:0] sx, sy;
	logic signed [36:0] rx, ry;
	logic signed [31:0] vx, vy;
	always_comb begin
		sx = 52'(pxc_s1) - 52'(pys_s1) + 52'sd32768;
		sy = 52'(pyc_s1) + 52'(pxs_s1) + 52'sd32768;
		rx = 37'(sx >>> 16) + 37'(posx_s1);
		ry = 37'(sy >>> 16) + 37'(posy_s1);
		vx = (rx > 37'sd2147483647) ? 32'sh7FFFFFFF :
		     ((rx < -37'sd2147483648) ? 32'sh80000000 : 32'(rx));
		vy = (ry > 37'sd2147483647) ? 32'sh7FFFFFFF :
		     ((ry < -37'sd2147483648) ? 32'sh80000000 : 32'(ry));
	end

	// Output register.
	always_ff @(posedge clk) begin
		if (adv2 && vld_s1) begin
			status_q <= rej_s1;
			last_q   <= last_s1;
			if (rej_s1) begin
				data_q <= '0;
			end else begin
				data_q <= {4'd0, tv_s1, tu_s1, color_s1, vy, vx, corner_s1, slot_s1};
			end
		end
	end

endmodule

@@ sv/sprite_quad_vertex_generator_core.sv @@
// Path: an accepted add passes 8 modulo steps, the fold, 16 CORDIC iterations, rounding
// and the queue push, then the multiply stage and the output register; a rejected add goes
// straight to the queue push. Begin and end are taken in the idle state with no output.
// The front part takes no new request until its add is pushed into the two-job queue;
// vertices leave one per cycle while m_tready allows, four per sprite, one for a reject.
// Reset: arst_n clears the batch state (closed, count zero) and all valid flags.
// ----------------------------------------------------------------------------
// sprite_quad_vertex_generator_core: sprite to quad vertex expansion
// Front part prepares sin, cos and corner offsets; back part emits vertices.
// ----------------------------------------------------------------------------
module sprite_quad_vertex_generator_core (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// pos_x, pos_y, width, height, pivot_x, pivot_y, angle_deg, color_in, uv_min, uv_max
	input  logic [319:0] s_tdata,
	// req_type
	input  logic [1:0]   s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// slot, corner, vert_x, vert_y, color_out, tex_u, tex_v, zero pad
	output logic [143:0] m_tdata,
	// status
	output logic         m_tuser,
	output logic         m_tlast
);

	logic           job_valid, job_full, job_avail, job_pop;
	sqvg_pkg::job_t job_in, job_head;

	sqvg_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.req_type  (s_tuser),
		.in_data   (s_tdata),
		.job_valid (job_valid),
		.job       (job_in),
		.job_full  (job_full)
	);

	sqvg_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (job_valid),
		.push_data (job_in),
		.full      (job_full),
		.pop       (job_pop),
		.avail     (job_avail),
		.head      (job_head)
	);

	sqvg_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.job_avail  (job_avail),
		.job        (job_head),
		.job_pop    (job_pop),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_data   (m_tdata),
		.out_status (m_tuser),
		.out_last   (m_tlast)
	);

	// A rejected sprite is a single, last, all-zero word.
	a_reject_word: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tlast && (m_tdata == '0))
		else $error("reject word not last or not zero");

	// A vertex word is last exactly on the fourth corner.
	a_vertex_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> (m_tlast == (m_tdata[11:10] == 2'd3)))
		else $error("last flag does not match corner");

	// The queue never pops when empty.
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		job_pop |-> job_avail)
		else $error("job popped from empty queue");

endmodule
